>>> hw/rtl/mlt_pkg.sv
// Shared types and constants for the Micro language tokenizer.
// Used by mlt_scanner and micro_language_tokenizer; depends on nothing.
package mlt_pkg;

  typedef enum logic [3:0] {
    KIND_BEGIN  = 4'd0,
    KIND_END    = 4'd1,
    KIND_READ   = 4'd2,
    KIND_WRITE  = 4'd3,
    KIND_ID     = 4'd4,
    KIND_LIT    = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_SEMI   = 4'd8,
    KIND_COMMA  = 4'd9,
    KIND_ASSIGN = 4'd10,
    KIND_PLUS   = 4'd11,
    KIND_MINUS  = 4'd12,
    KIND_EOF    = 4'd13,
    KIND_ERROR  = 4'd14
  } kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_IDENT   = 6'b000010,
    MODE_NUMBER  = 6'b000100,
    MODE_COLON   = 6'b001000,
    MODE_MINUS   = 6'b010000,
    MODE_COMMENT = 6'b100000
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [30:0] value;
    logic [5:0]  len;
    logic [7:0]  bad;
    logic        last;
  } res_t;

  localparam res_t RES_NONE = '{kind: KIND_EOF, value: '0, len: '0, bad: '0, last: 1'b0};

  // Keyword spellings in upper case, first character in the low byte.
  localparam logic [39:0] KW_BEGIN = 40'h4E_49_47_45_42;
  localparam logic [39:0] KW_END   = 40'h00_00_44_4E_45;
  localparam logic [39:0] KW_READ  = 40'h00_44_41_45_52;
  localparam logic [39:0] KW_WRITE = 40'h45_54_49_52_57;

  localparam int unsigned KW_LEN_BEGIN = 5;
  localparam int unsigned KW_LEN_END   = 3;
  localparam int unsigned KW_LEN_READ  = 4;
  localparam int unsigned KW_LEN_WRITE = 5;
  localparam int unsigned CAPTURE_CHARS = 5;

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
  localparam logic [7:0]  CH_EQUAL   = 8'h3D;
  localparam logic [7:0]  CH_NEWLINE = 8'h0A;
  localparam logic [7:0]  CH_COLON   = 8'h3A;
  localparam logic [7:0]  CH_DASH    = 8'h2D;
  localparam logic [7:0]  CH_UNDER   = 8'h5F;
  localparam logic [7:0]  CH_LPAREN  = 8'h28;
  localparam logic [7:0]  CH_RPAREN  = 8'h29;
  localparam logic [7:0]  CH_SEMI    = 8'h3B;
  localparam logic [7:0]  CH_COMMA   = 8'h2C;
  localparam logic [7:0]  CH_PLUS    = 8'h2B;
  localparam logic [7:0]  CH_SPACE   = 8'h20;

endpackage

>>> hw/rtl/mlt_scanner.sv
// Scanner state and per-character step logic for the Micro language tokenizer.
// Depends on mlt_pkg; produces up to two tokens for each accepted character.
module mlt_scanner #(
  parameter int unsigned MAX_LEXEME = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      ch_i,
  input  logic            end_mark_i,
  output mlt_pkg::res_t   res_o [2],
  output logic [1:0]      n_o
);

  localparam int unsigned CntW = $clog2(MAX_LEXEME + 1);

  mlt_pkg::mode_e  mode_q, mode_d;
  logic [39:0]     cap_q, cap_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [30:0]     val_q, val_d;
  logic [1:0]      mix_q, mix_d;

  logic            is_up, is_lo, is_dg, is_sp, is_word;
  logic [7:0]      fold;
  logic            single_case;
  mlt_pkg::kind_e  word_kind;
  logic [5:0]      out_len;
  logic            fl_valid, st_valid, brk;
  mlt_pkg::res_t   fl_tok, st_tok, r0, r1;
  logic [1:0]      n;
  mlt_pkg::mode_e  st_mode;
  logic [39:0]     st_cap, cap_add;
  logic [CntW-1:0] st_cnt, cnt_inc;
  logic [30:0]     st_val, val_acc;
  logic [1:0]      st_mix;
  logic [34:0]     prod;

  always_comb begin
    is_up   = (ch_i >= 8'h41) && (ch_i <= 8'h5A);
    is_lo   = (ch_i >= 8'h61) && (ch_i <= 8'h7A);
    is_dg   = (ch_i >= 8'h30) && (ch_i <= 8'h39);
    is_sp   = (ch_i == mlt_pkg::CH_SPACE) || ((ch_i >= 8'd9) && (ch_i <= 8'd13));
    is_word = is_up || is_lo || is_dg || (ch_i == mlt_pkg::CH_UNDER);
    fold    = is_lo ? (ch_i - 8'd32) : ch_i;
  end

  // Keyword match only for words spelled in a single case.
  always_comb begin
    single_case = (mix_q == 2'b01) || (mix_q == 2'b10);
    word_kind   = mlt_pkg::KIND_ID;
    if (single_case) begin
      priority if ((cnt_q == CntW'(mlt_pkg::KW_LEN_BEGIN)) && (cap_q == mlt_pkg::KW_BEGIN)) begin
        word_kind = mlt_pkg::KIND_BEGIN;
      end else if ((cnt_q == CntW'(mlt_pkg::KW_LEN_END)) && (cap_q == mlt_pkg::KW_END)) begin
        word_kind = mlt_pkg::KIND_END;
      end else if ((cnt_q == CntW'(mlt_pkg::KW_LEN_READ)) && (cap_q == mlt_pkg::KW_READ)) begin
        word_kind = mlt_pkg::KIND_READ;
      end else if ((cnt_q == CntW'(mlt_pkg::KW_LEN_WRITE)) && (cap_q == mlt_pkg::KW_WRITE)) begin
        word_kind = mlt_pkg::KIND_WRITE;
      end else begin
        word_kind = mlt_pkg::KIND_ID;
      end
    end
    out_len = (32'(cnt_q) > 32'd63) ? 6'd63 : 6'(cnt_q);
  end

  // Token pending in the current mode, emitted when a character or the end mark ends it.
  always_comb begin
    fl_tok   = mlt_pkg::RES_NONE;
    fl_valid = 1'b0;
    unique case (mode_q)
      mlt_pkg::MODE_IDENT: begin
        fl_valid    = 1'b1;
        fl_tok.kind = word_kind;
        fl_tok.len  = out_len;
      end
      mlt_pkg::MODE_NUMBER: begin
        fl_valid     = 1'b1;
        fl_tok.kind  = mlt_pkg::KIND_LIT;
        fl_tok.value = val_q;
        fl_tok.len   = out_len;
      end
      mlt_pkg::MODE_COLON: begin
        fl_valid    = 1'b1;
        fl_tok.kind = mlt_pkg::KIND_ERROR;
        fl_tok.bad  = mlt_pkg::CH_COLON;
      end
      mlt_pkg::MODE_MINUS: begin
        fl_valid    = 1'b1;
        fl_tok.kind = mlt_pkg::KIND_MINUS;
      end
      default: fl_valid = 1'b0;
    endcase
  end

  // The character seen as the start of a new token.
  always_comb begin
    st_tok   = mlt_pkg::RES_NONE;
    st_valid = 1'b0;
    st_mode  = mlt_pkg::MODE_IDLE;
    st_cap   = '0;
    st_cnt   = '0;
    st_val   = '0;
    st_mix   = '0;
    priority if (is_sp) begin
      st_mode = mlt_pkg::MODE_IDLE;
    end else if (is_up || is_lo) begin
      st_mode = mlt_pkg::MODE_IDENT;
      st_cap  = {32'd0, fold};
      st_cnt  = CntW'(1);
      st_mix  = {is_lo, is_up};
    end else if (is_dg) begin
      st_mode = mlt_pkg::MODE_NUMBER;
      st_val  = {27'd0, ch_i[3:0]};
      st_cnt  = CntW'(1);
    end else if (ch_i == mlt_pkg::CH_COLON) begin
      st_mode = mlt_pkg::MODE_COLON;
    end else if (ch_i == mlt_pkg::CH_DASH) begin
      st_mode = mlt_pkg::MODE_MINUS;
    end else begin
      st_valid = 1'b1;
      priority if (ch_i == mlt_pkg::CH_LPAREN) begin
        st_tok.kind = mlt_pkg::KIND_LPAREN;
      end else if (ch_i == mlt_pkg::CH_RPAREN) begin
        st_tok.kind = mlt_pkg::KIND_RPAREN;
      end else if (ch_i == mlt_pkg::CH_SEMI) begin
        st_tok.kind = mlt_pkg::KIND_SEMI;
      end else if (ch_i == mlt_pkg::CH_COMMA) begin
        st_tok.kind = mlt_pkg::KIND_COMMA;
      end else if (ch_i == mlt_pkg::CH_PLUS) begin
        st_tok.kind = mlt_pkg::KIND_PLUS;
      end else begin
        st_tok.kind = mlt_pkg::KIND_ERROR;
        st_tok.bad  = ch_i;
      end
    end
  end

  // Continuing a word or a literal.
  always_comb begin
    cap_add = cap_q;
    if (cnt_q < CntW'(mlt_pkg::CAPTURE_CHARS)) begin
      cap_add[8*cnt_q[2:0] +: 8] = fold;
    end
    cnt_inc = (cnt_q < CntW'(MAX_LEXEME)) ? (cnt_q + CntW'(1)) : cnt_q;
    prod    = ({4'd0, val_q} << 3) + ({4'd0, val_q} << 1) + {31'd0, ch_i[3:0]};
    val_acc = (prod > {4'd0, mlt_pkg::VALUE_MAX}) ? mlt_pkg::VALUE_MAX : prod[30:0];
  end

  always_comb begin
    mode_d = mode_q;
    cap_d  = cap_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    mix_d  = mix_q;
    r0     = mlt_pkg::RES_NONE;
    r1     = mlt_pkg::RES_NONE;
    n      = 2'd0;
    brk    = 1'b0;
    if (end_mark_i) begin
      mode_d = mlt_pkg::MODE_IDLE;
      cap_d  = '0;
      cnt_d  = '0;
      val_d  = '0;
      mix_d  = '0;
      if (fl_valid) begin
        r0      = fl_tok;
        r1.kind = mlt_pkg::KIND_EOF;
        n       = 2'd2;
      end else begin
        r0.kind = mlt_pkg::KIND_EOF;
        n       = 2'd1;
      end
    end else begin
      unique case (mode_q)
        mlt_pkg::MODE_IDENT: begin
          if (is_word) begin
            cap_d = cap_add;
            cnt_d = cnt_inc;
            mix_d = mix_q | {is_lo, is_up};
          end else begin
            brk = 1'b1;
          end
        end
        mlt_pkg::MODE_NUMBER: begin
          if (is_dg) begin
            val_d = val_acc;
            cnt_d = cnt_inc;
          end else begin
            brk = 1'b1;
          end
        end
        mlt_pkg::MODE_COLON: begin
          if (ch_i == mlt_pkg::CH_EQUAL) begin
            mode_d  = mlt_pkg::MODE_IDLE;
            r0.kind = mlt_pkg::KIND_ASSIGN;
            n       = 2'd1;
          end else begin
            brk = 1'b1;
          end
        end
        mlt_pkg::MODE_MINUS: begin
          if (ch_i == mlt_pkg::CH_DASH) begin
            mode_d = mlt_pkg::MODE_COMMENT;
          end else begin
            brk = 1'b1;
          end
        end
        mlt_pkg::MODE_COMMENT: begin
          if (ch_i == mlt_pkg::CH_NEWLINE) begin
            mode_d = mlt_pkg::MODE_IDLE;
          end
        end
        mlt_pkg::MODE_IDLE: brk = 1'b1;
        default: mode_d = mlt_pkg::MODE_IDLE;
      endcase
      // The character that ends a token is scanned again as a fresh start.
      if (brk) begin
        mode_d = st_mode;
        cap_d  = st_cap;
        cnt_d  = st_cnt;
        val_d  = st_val;
        mix_d  = st_mix;
        if (fl_valid && st_valid) begin
          r0 = fl_tok;
          r1 = st_tok;
          n  = 2'd2;
        end else if (fl_valid) begin
          r0 = fl_tok;
          n  = 2'd1;
        end else if (st_valid) begin
          r0 = st_tok;
          n  = 2'd1;
        end
      end
    end
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign res_o[0] = r0;
  assign res_o[1] = r1;
  assign n_o      = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mlt_pkg::MODE_IDLE;
      cap_q  <= '0;
      cnt_q  <= '0;
      val_q  <= '0;
      mix_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cap_q  <= cap_d;
      cnt_q  <= cnt_d;
      val_q  <= val_d;
      mix_q  <= mix_d;
    end
  end

  a_two_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (n_o == 2'd2)) |-> (!res_o[0].last && res_o[1].last))
    else $error("two-token step must flag only the second token as last");

  a_eof_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && end_mark_i) |->
      (((n_o == 2'd1) && (res_o[0].kind == mlt_pkg::KIND_EOF)) ||
       ((n_o == 2'd2) && (res_o[1].kind == mlt_pkg::KIND_EOF))))
    else $error("end mark must finish with an eof token");

  a_eof_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && end_mark_i) |=> (mode_q == mlt_pkg::MODE_IDLE))
    else $error("scanner not idle after end mark");

  a_comment_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !end_mark_i && (mode_q == mlt_pkg::MODE_COMMENT)) |-> (n_o == 2'd0))
    else $error("token emitted inside a comment");

endmodule

>>> hw/rtl/micro_language_tokenizer.sv
// A token is registered into the output queue when the item that completes it is accepted, and is shown from slot 0.
// Throughput: one item per cycle while each item yields at most one token and the consumer
// keeps up; an item yielding two tokens fills two entries of a three-entry queue and input waits.
// in_ready_o depends only on the queue fill, never combinationally on out_ready_i.
// Reset (rst_ni low, asynchronous) returns the scanner to idle and empties the queue.
// Top level of the Micro language tokenizer; depends on mlt_pkg and mlt_scanner.
module micro_language_tokenizer #(
  parameter int unsigned MAX_LEXEME = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        end_mark_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [30:0] literal_value_o,
  output logic [5:0]  lexeme_length_o,
  output logic [7:0]  bad_char_o,
  output logic        last_o
);

  // The scanner updates its mode and lexeme registers on every accepted item and
  // hands back up to two finished tokens in the same cycle.
  mlt_pkg::res_t res [2];
  logic [1:0]    res_n;
  logic          accept;

  assign accept = in_valid_i && in_ready_o;

  mlt_scanner #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_scanner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .ch_i       (ch_i),
    .end_mark_i (end_mark_i),
    .res_o      (res),
    .n_o        (res_n)
  );

  // Output queue: slot 0 is the output register; slots shift down on every pop and new
  // tokens are appended right behind the surviving entries. Input is taken only while
  // two slots are certainly free, so a two-token item never overflows.
  mlt_pkg::res_t q_q [3];
  mlt_pkg::res_t q_d [3];
  mlt_pkg::res_t sh [3];
  logic [1:0]    cnt_q, cnt_d;
  logic [1:0]    base;
  logic [1:0]    push_n;
  logic          pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign in_ready_o  = (cnt_q <= 2'd1);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    base   = cnt_q - {1'b0, pop};
    push_n = accept ? res_n : 2'd0;
    sh[0]  = pop ? q_q[1] : q_q[0];
    sh[1]  = pop ? q_q[2] : q_q[1];
    sh[2]  = q_q[2];
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < base) begin
        q_d[i] = sh[i];
      end else if (2'(i) == base) begin
        q_d[i] = res[0];
      end else if (2'(i) == (base + 2'd1)) begin
        q_d[i] = res[1];
      end else begin
        q_d[i] = sh[i];
      end
    end
    cnt_d = base + push_n;
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign kind_o          = q_q[0].kind;
  assign literal_value_o = q_q[0].value;
  assign lexeme_length_o = q_q[0].len;
  assign bad_char_o      = q_q[0].bad;
  assign last_o          = q_q[0].last;

  a_token_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (res_n != 2'd0)) |=> out_valid_o)
    else $error("token produced but no item offered on the output");

  a_fill_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pop && accept) |=> (cnt_q >= $past(cnt_q)))
    else $error("queue fill dropped without a pop");

  a_last_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (res_n == 2'd2) && !pop && (cnt_q == 2'd0)) |=> (!q_q[0].last && q_q[1].last))
    else $error("two-token item queued out of order");

endmodule
